>>> sv/mclb_pkg.sv
// Package for the multi-channel LED blinker: sizes, command codes, state encoding.
package mclb_pkg;

    localparam int CHANNELS  = 8;
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MASK_W    = (CHANNELS < 8) ? CHANNELS : 8;

    localparam int CMD_W     = 3;
    localparam int CHAN_IN_W = 8;
    localparam int COUNT_W   = 32;
    localparam int TIME_W    = 32;
    localparam int SPAN_W    = 16;
    localparam int PER_W     = SPAN_W + 1;

    localparam int DIV_STEPS = TIME_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // start-all defaults
    localparam logic [COUNT_W-1:0] ALL_COUNT = COUNT_W'(100);
    localparam logic [SPAN_W-1:0]  ALL_ON    = SPAN_W'(10000);
    localparam logic [SPAN_W-1:0]  ALL_OFF   = SPAN_W'(0);

    localparam logic [CMD_W-1:0] CMD_START_ONE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START_ALL = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP_ONE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STOP_ALL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REFRESH   = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DIV    = 5'b00100,
        S_FIN    = 5'b01000,
        S_REPORT = 5'b10000
    } t_state;

    typedef logic [CHANNELS-1:0] t_chan_bits;

endpackage

>>> sv/multi_channel_led_blinker.sv
// Multi-channel LED blinker: command decode, per-channel state, shared divider sequencer.
//
//  channel | direction | ports                                         | handshake
//  --------+-----------+-----------------------------------------------+----------------------
//  command | in        | i_command i_channel i_blink_count i_on_time   | start high, busy low
//          |           | i_off_time i_now                              |
//  result  | out       | o_led_mask o_active_mask o_status             | o_strobe, one cycle
//
//  Start, stop and unknown commands pass from acceptance through S_REPORT to the
//  registered o_strobe. Refresh walks the channels in turn through one shared
//  restoring divider (one quotient bit a cycle): an idle channel passes S_SCAN only,
//  an active one S_SCAN, S_DIV and S_FIN, and the walk ends in S_REPORT.
//  busy is high from acceptance until the result word is shown; the receiver
//  cannot stall, so o_strobe lasts exactly one cycle. Synchronous reset clears
//  all channels to idle and dark.
module multi_channel_led_blinker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [mclb_pkg::CMD_W-1:0]          i_command,
    input  logic [mclb_pkg::CHAN_IN_W-1:0]      i_channel,
    input  logic [mclb_pkg::COUNT_W-1:0]        i_blink_count,
    input  logic [mclb_pkg::SPAN_W-1:0]         i_on_time,
    input  logic [mclb_pkg::SPAN_W-1:0]         i_off_time,
    input  logic [mclb_pkg::TIME_W-1:0]         i_now,
    output logic                                o_strobe,
    output logic [7:0]                          o_led_mask,
    output logic [7:0]                          o_active_mask,
    output logic                                o_status
);

    // control state
    mclb_pkg::t_state                 r_state,  n_state;
    mclb_pkg::t_chan_bits             r_active, n_active;
    mclb_pkg::t_chan_bits             r_lit,    n_lit;
    logic                             r_strobe, n_strobe;
    logic [mclb_pkg::CH_W-1:0]        r_chan,   n_chan;
    logic [mclb_pkg::STEP_W-1:0]      r_step,   n_step;

    // per-channel settings (only read while the channel is active)
    logic [mclb_pkg::COUNT_W-1:0]     r_count [mclb_pkg::CHANNELS];
    logic [mclb_pkg::COUNT_W-1:0]     n_count [mclb_pkg::CHANNELS];
    logic [mclb_pkg::SPAN_W-1:0]      r_span  [mclb_pkg::CHANNELS];
    logic [mclb_pkg::SPAN_W-1:0]      n_span  [mclb_pkg::CHANNELS];
    logic [mclb_pkg::PER_W-1:0]       r_per   [mclb_pkg::CHANNELS];
    logic [mclb_pkg::PER_W-1:0]       n_per   [mclb_pkg::CHANNELS];
    logic [mclb_pkg::TIME_W-1:0]      r_stamp [mclb_pkg::CHANNELS];
    logic [mclb_pkg::TIME_W-1:0]      n_stamp [mclb_pkg::CHANNELS];

    // divider and result payload
    logic [mclb_pkg::TIME_W-1:0]      r_now,     n_now;
    logic [mclb_pkg::TIME_W-1:0]      r_quo,     n_quo;
    logic [mclb_pkg::PER_W-1:0]       r_rem,     n_rem;
    logic [mclb_pkg::PER_W-1:0]       r_div_per, n_div_per;
    logic                             r_status,  n_status;
    logic [7:0]                       r_led,     n_led;
    logic [7:0]                       r_act,     n_act;

    logic                             accept;
    logic                             last_chan;
    logic [mclb_pkg::CH_W-1:0]        ch_idx;
    logic                             ch_ok;
    logic [mclb_pkg::PER_W:0]         rem_sh;
    logic [mclb_pkg::PER_W:0]         rem_diff;
    logic                             rem_ge;

    assign busy      = (r_state != mclb_pkg::S_IDLE);
    assign accept    = start && !busy;
    assign last_chan = (r_chan == mclb_pkg::CH_W'(mclb_pkg::CHANNELS - 1));
    assign ch_ok     = (32'(i_channel) < 32'(mclb_pkg::CHANNELS));
    assign ch_idx    = i_channel[mclb_pkg::CH_W-1:0];

    // one restoring-division step: bring in the next dividend bit, trial subtract
    assign rem_sh   = {r_rem, r_quo[mclb_pkg::TIME_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_div_per};
    assign rem_ge   = (rem_sh >= {1'b0, r_div_per});

    always_comb begin
        n_state   = r_state;
        n_active  = r_active;
        n_lit     = r_lit;
        n_strobe  = 1'b0;
        n_chan    = r_chan;
        n_step    = r_step;
        n_count   = r_count;
        n_span    = r_span;
        n_per     = r_per;
        n_stamp   = r_stamp;
        n_now     = r_now;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_div_per = r_div_per;
        n_status  = r_status;
        n_led     = r_led;
        n_act     = r_act;

        case (r_state)
            mclb_pkg::S_IDLE: begin
                if (accept) begin
                    n_status = 1'b0;
                    n_now    = i_now;
                    n_state  = mclb_pkg::S_REPORT;
                    case (i_command)
                        mclb_pkg::CMD_START_ONE: begin
                            if (!ch_ok || r_active[ch_idx] ||
                                i_blink_count == '0 || i_on_time == '0) begin
                                n_status = 1'b1;
                            end else begin
                                n_count[ch_idx]  = i_blink_count;
                                n_span[ch_idx]   = i_on_time;
                                n_per[ch_idx]    = {1'b0, i_on_time} + {1'b0, i_off_time};
                                n_stamp[ch_idx]  = i_now;
                                n_active[ch_idx] = 1'b1;
                                n_lit[ch_idx]    = 1'b1;
                            end
                        end
                        mclb_pkg::CMD_START_ALL: begin
                            for (int c = 0; c < mclb_pkg::CHANNELS; c++) begin
                                if (!r_active[c]) begin
                                    n_count[c]  = mclb_pkg::ALL_COUNT;
                                    n_span[c]   = mclb_pkg::ALL_ON;
                                    n_per[c]    = {1'b0, mclb_pkg::ALL_ON}
                                                + {1'b0, mclb_pkg::ALL_OFF};
                                    n_stamp[c]  = i_now;
                                    n_active[c] = 1'b1;
                                    n_lit[c]    = 1'b1;
                                end
                            end
                        end
                        mclb_pkg::CMD_STOP_ONE: begin
                            if (ch_ok) begin
                                n_active[ch_idx] = 1'b0;
                                n_lit[ch_idx]    = 1'b0;
                            end else begin
                                n_status = 1'b1;
                            end
                        end
                        mclb_pkg::CMD_STOP_ALL: begin
                            n_active = '0;
                            n_lit    = '0;
                        end
                        mclb_pkg::CMD_REFRESH: begin
                            n_chan  = '0;
                            n_state = mclb_pkg::S_SCAN;
                        end
                        default: begin
                            n_status = 1'b1;
                        end
                    endcase
                end
            end

            mclb_pkg::S_SCAN: begin
                if (r_active[r_chan]) begin
                    n_quo     = r_now - r_stamp[r_chan];
                    n_rem     = '0;
                    n_div_per = (r_per[r_chan] == '0) ? mclb_pkg::PER_W'(1) : r_per[r_chan];
                    n_step    = '0;
                    n_state   = mclb_pkg::S_DIV;
                end else if (last_chan) begin
                    n_state = mclb_pkg::S_REPORT;
                end else begin
                    n_chan = r_chan + 1'b1;
                end
            end

            mclb_pkg::S_DIV: begin
                // quotient bits shift into the dividend register from the bottom
                n_quo = {r_quo[mclb_pkg::TIME_W-2:0], rem_ge};
                n_rem = rem_ge ? rem_diff[mclb_pkg::PER_W-1:0] : rem_sh[mclb_pkg::PER_W-1:0];
                n_step = r_step + 1'b1;
                if (r_step == mclb_pkg::STEP_W'(mclb_pkg::DIV_STEPS - 1)) begin
                    n_state = mclb_pkg::S_FIN;
                end
            end

            mclb_pkg::S_FIN: begin
                n_lit[r_chan] = (r_rem < {1'b0, r_span[r_chan]});
                if (r_quo >= r_count[r_chan]) begin
                    n_active[r_chan] = 1'b0;
                    n_lit[r_chan]    = 1'b0;
                end
                if (last_chan) begin
                    n_state = mclb_pkg::S_REPORT;
                end else begin
                    n_chan  = r_chan + 1'b1;
                    n_state = mclb_pkg::S_SCAN;
                end
            end

            mclb_pkg::S_REPORT: begin
                n_led    = 8'(r_lit[mclb_pkg::MASK_W-1:0]);
                n_act    = 8'(r_active[mclb_pkg::MASK_W-1:0]);
                n_strobe = 1'b1;
                n_state  = mclb_pkg::S_IDLE;
            end

            default: begin
                n_state = mclb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mclb_pkg::S_IDLE;
            r_active <= '0;
            r_lit    <= '0;
            r_strobe <= 1'b0;
            r_chan   <= '0;
            r_step   <= '0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_lit    <= n_lit;
            r_strobe <= n_strobe;
            r_chan   <= n_chan;
            r_step   <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count   <= n_count;
        r_span    <= n_span;
        r_per     <= n_per;
        r_stamp   <= n_stamp;
        r_now     <= n_now;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_div_per <= n_div_per;
        r_status  <= n_status;
        r_led     <= n_led;
        r_act     <= n_act;
    end

    assign o_strobe      = r_strobe;
    assign o_led_mask    = r_led;
    assign o_active_mask = r_act;
    assign o_status      = r_status;

    // a word is only shown straight after the report cycle
    a_strobe_after_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == mclb_pkg::S_REPORT))
        else $error("result strobe without report cycle");

    // refresh always starts the channel walk
    a_refresh_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == mclb_pkg::CMD_REFRESH) |=> (r_state == mclb_pkg::S_SCAN))
        else $error("refresh did not start the channel walk");

    // an idle channel is never lit
    a_lit_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lit & ~r_active) == '0)
        else $error("LED lit on an idle channel");

    // the partial remainder stays below the divisor throughout the division
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mclb_pkg::S_DIV || r_state == mclb_pkg::S_FIN) |-> (r_rem < r_div_per))
        else $error("divider remainder out of range");

    // the block is ready again when the word is shown
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("busy while result word shown");

endmodule
